// File: hw/rtl/sws_pkg.sv
`timescale 1ns / 1ps

package sws_pkg;

  // window size register width and its reset value
  localparam int unsigned WsBits = 9;
  localparam logic [WsBits-1:0] WsReset = 9'd256;

  // register indexes
  localparam int unsigned RegWindowSize = 0;

  // input op codes
  localparam logic OpPush  = 1'b0;
  localparam logic OpClear = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StRdOld,
    StSqOld,
    StAccum,
    StPrep,
    StVSub,
    StDivMean,
    StDivVar,
    StRoot,
    StScan,
    StFin
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd_old;
    logic sq_old;
    logic accum;
    logic prep;
    logic vsub;
    logic div_mean_start;
    logic div_var_start;
    logic sqrt_start;
    logic scan_start;
    logic load_res;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic scan_busy;
  } status_t;

endpackage

// File: hw/rtl/sliding_window_statistics.sv
`timescale 1ns / 1ps
// a clear or a push with zero window size goes to the final state and gives an empty result
// a push runs two serial divides, a serial square root and a min/max walk over the ring
// throughput: one item at a time, next beat taken once the current item leaves the datapath
// reset: asynchronous active low, empty window, window_size 256, ring contents undefined

module sliding_window_statistics #(
  parameter int unsigned MAX_DEPTH   = 256,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic signed [SAMPLE_BITS-1:0]  sample_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           valid_res_o,
  output logic [$clog2(MAX_DEPTH+1)-1:0] held_count_o,
  output logic signed [SAMPLE_BITS-1:0]  mean_value_o,
  output logic [2*SAMPLE_BITS-2:0]       variance_value_o,
  output logic [SAMPLE_BITS-1:0]         deviation_value_o,
  output logic signed [SAMPLE_BITS-1:0]  smallest_o,
  output logic signed [SAMPLE_BITS-1:0]  largest_o,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned CW = $clog2(MAX_DEPTH + 1);

  logic [sws_pkg::WsBits-1:0] ws_q;
  logic [CW-1:0]              cap;
  logic                       cfg_we;
  logic                       clear;
  sws_pkg::cmd_t              cmd;
  sws_pkg::status_t           status;

  assign pready = 1'b1;

  // only the window size register exists, at byte address zero
  assign cfg_we = psel && penable && pwrite && (paddr == 3'(4 * sws_pkg::RegWindowSize));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= sws_pkg::WsReset;
    end else if (cfg_we) begin
      ws_q <= pwdata[sws_pkg::WsBits-1:0];
    end
  end

  always_comb begin
    if (paddr == 3'(4 * sws_pkg::RegWindowSize)) prdata = 32'(ws_q);
    else prdata = '0;
  end

  // window size saturates at the ring depth
  always_comb begin
    if (32'(ws_q) > 32'(MAX_DEPTH)) cap = CW'(MAX_DEPTH);
    else cap = CW'(ws_q);
  end

  // a size write and a clear beat both empty the window
  assign clear = cfg_we || (cmd.accept && op_i == sws_pkg::OpClear);

  sws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .cap_zero_i  (cap == '0),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  sws_dp #(
    .MAX_DEPTH   (MAX_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .clear_i           (clear),
    .op_i              (op_i),
    .sample_i          (sample_i),
    .cap_i             (cap),
    .status_o          (status),
    .valid_res_o       (valid_res_o),
    .held_count_o      (held_count_o),
    .mean_value_o      (mean_value_o),
    .variance_value_o  (variance_value_o),
    .deviation_value_o (deviation_value_o),
    .smallest_o        (smallest_o),
    .largest_o         (largest_o)
  );

endmodule

// File: hw/rtl/sws_ctrl.sv
`timescale 1ns / 1ps

module sws_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              op_i,
  input  logic              cap_zero_i,
  input  logic              out_stall_i,
  input  sws_pkg::status_t  status_i,
  output sws_pkg::cmd_t     cmd_o,
  output logic              in_stall_o,
  output logic              out_valid_o
);

  sws_pkg::state_e state_q, state_d;
  logic            ov_q, ov_d;
  logic            accept;

  assign in_stall_o  = (state_q != sws_pkg::StIdle);
  assign accept      = in_valid_i && (state_q == sws_pkg::StIdle);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sws_pkg::StIdle: begin
        if (accept) begin
          if (op_i == sws_pkg::OpClear || cap_zero_i) state_d = sws_pkg::StFin;
          else state_d = sws_pkg::StRdOld;
        end
      end
      sws_pkg::StRdOld:   state_d = sws_pkg::StSqOld;
      sws_pkg::StSqOld:   state_d = sws_pkg::StAccum;
      sws_pkg::StAccum:   state_d = sws_pkg::StPrep;
      sws_pkg::StPrep:    state_d = sws_pkg::StVSub;
      sws_pkg::StVSub:    state_d = sws_pkg::StDivMean;
      sws_pkg::StDivMean: if (!status_i.div_busy) state_d = sws_pkg::StDivVar;
      sws_pkg::StDivVar:  if (!status_i.div_busy) state_d = sws_pkg::StRoot;
      sws_pkg::StRoot:    if (!status_i.sqrt_busy) state_d = sws_pkg::StScan;
      sws_pkg::StScan:    if (!status_i.scan_busy) state_d = sws_pkg::StFin;
      sws_pkg::StFin:     if (!ov_q || !out_stall_i) state_d = sws_pkg::StIdle;
      default:            state_d = sws_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      sws_pkg::StIdle:    cmd_o.accept = accept;
      sws_pkg::StRdOld:   cmd_o.rd_old = 1'b1;
      sws_pkg::StSqOld:   cmd_o.sq_old = 1'b1;
      sws_pkg::StAccum:   cmd_o.accum = 1'b1;
      sws_pkg::StPrep:    cmd_o.prep = 1'b1;
      sws_pkg::StVSub: begin
        cmd_o.vsub           = 1'b1;
        cmd_o.div_mean_start = 1'b1;
      end
      sws_pkg::StDivMean: cmd_o.div_var_start = !status_i.div_busy;
      sws_pkg::StDivVar:  cmd_o.sqrt_start = !status_i.div_busy;
      sws_pkg::StRoot:    cmd_o.scan_start = !status_i.sqrt_busy;
      sws_pkg::StScan:    cmd_o = '0;
      sws_pkg::StFin:     cmd_o.load_res = !ov_q || !out_stall_i;
      default:            cmd_o = '0;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (cmd_o.load_res) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sws_pkg::StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// File: hw/rtl/sws_dp.sv
`timescale 1ns / 1ps

module sws_dp #(
  parameter int unsigned MAX_DEPTH   = 256,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sws_pkg::cmd_t                  cmd_i,
  input  logic                           clear_i,
  input  logic                           op_i,
  input  logic signed [SAMPLE_BITS-1:0]  sample_i,
  input  logic [$clog2(MAX_DEPTH+1)-1:0] cap_i,
  output sws_pkg::status_t               status_o,
  output logic                           valid_res_o,
  output logic [$clog2(MAX_DEPTH+1)-1:0] held_count_o,
  output logic signed [SAMPLE_BITS-1:0]  mean_value_o,
  output logic [2*SAMPLE_BITS-2:0]       variance_value_o,
  output logic [SAMPLE_BITS-1:0]         deviation_value_o,
  output logic signed [SAMPLE_BITS-1:0]  smallest_o,
  output logic signed [SAMPLE_BITS-1:0]  largest_o
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned CW  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW  = $clog2(MAX_DEPTH);
  localparam int unsigned SW  = SB + CW;
  localparam int unsigned SQW = 2 * SB + CW - 1;
  localparam int unsigned VW  = 2 * SB - 1;
  localparam int unsigned DVW = CW + SQW;
  localparam int unsigned DSW = 2 * CW;
  localparam int unsigned DCW = $clog2(DVW + 1);
  localparam int unsigned RCW = $clog2(SB + 1);

  // sample ring
  logic [SB-1:0] mem_q [MAX_DEPTH];
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [SB-1:0] rdata_q;

  // window state
  logic [AW-1:0]        wp_q;
  logic [CW-1:0]        fill_q;
  logic signed [SW-1:0] sum_q;
  logic [SQW-1:0]       sq_q;
  logic signed [SB-1:0] s_q;
  logic                 zero_q;
  logic                 full;

  // squaring and variance prep
  logic signed [2*SB-1:0] prod_q;
  logic [2*SB-1:0]        newsq_q;
  logic [SW-1:0]          absv, abs_q;
  logic                   neg_q;
  logic [DVW-1:0]         nsq_q, num_q;
  logic [2*SW-1:0]        asq_q;
  logic [DSW-1:0]         nn_q;

  // divider
  logic [DVW-1:0] dq_q, dq_nx;
  logic [DSW-1:0] dr_q, dd_q, dr_nx;
  logic [DSW:0]   dsh;
  logic [DCW-1:0] dcnt_q;
  logic           dbusy_q, dsel_var_q;

  // square root
  logic [2*SB-1:0] sx_q;
  logic [SB+1:0]   sr_q, srn, trial;
  logic [SB-1:0]   root_q;
  logic [RCW-1:0]  rcnt_q;
  logic            rbusy_q;

  // min / max scan
  logic [CW-1:0]        idx_q;
  logic                 run_q, pend_q, first_q;
  logic signed [SB-1:0] lo_q, hi_q, rd_s;

  // statistics
  logic signed [SB-1:0] mean_q;
  logic [VW-1:0]        var_q;

  assign full    = (fill_q >= cap_i);
  assign rd_en   = cmd_i.rd_old || (run_q && (idx_q < fill_q));
  assign rd_addr = run_q ? idx_q[AW-1:0] : wp_q;
  assign rd_s    = signed'(rdata_q);
  assign absv    = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);

  assign status_o.div_busy  = dbusy_q;
  assign status_o.sqrt_busy = rbusy_q;
  assign status_o.scan_busy = run_q || pend_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem_q[rd_addr];
    if (cmd_i.accum) mem_q[wp_q] <= s_q;
  end

  // window bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      zero_q <= 1'b0;
    end else if (clear_i) begin
      wp_q   <= '0;
      fill_q <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      zero_q <= 1'b1;
    end else if (cmd_i.accept) begin
      zero_q <= (cap_i == '0);
      if (CW'(wp_q) >= cap_i) wp_q <= '0;
    end else if (cmd_i.accum) begin
      if (full) begin
        sum_q <= sum_q - SW'(signed'(rdata_q)) + SW'(s_q);
        sq_q  <= sq_q - SQW'(prod_q) + SQW'(newsq_q);
      end else begin
        sum_q  <= sum_q + SW'(s_q);
        sq_q   <= sq_q + SQW'(newsq_q);
        fill_q <= fill_q + 1'b1;
      end
      if (CW'(wp_q) + 1'b1 >= cap_i) wp_q <= '0;
      else wp_q <= wp_q + 1'b1;
    end
  end

  // sample capture, squares, variance numerator
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && op_i == sws_pkg::OpPush) s_q <= sample_i;
    if (cmd_i.rd_old) prod_q <= s_q * s_q;
    if (cmd_i.sq_old) begin
      newsq_q <= prod_q;
      prod_q  <= rd_s * rd_s;
    end
    if (cmd_i.prep) begin
      abs_q <= absv;
      neg_q <= sum_q[SW-1];
      asq_q <= absv * absv;
      nsq_q <= DVW'(fill_q * sq_q);
      nn_q  <= fill_q * fill_q;
    end
    if (cmd_i.vsub) begin
      if ((2*SW)'(nsq_q) >= asq_q) num_q <= DVW'((2*SW)'(nsq_q) - asq_q);
      else num_q <= '0;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_comb begin
    dsh   = {dr_q, dq_q[DVW-1]};
    dq_nx = {dq_q[DVW-2:0], 1'b0};
    dr_nx = dsh[DSW-1:0];
    if (dsh >= {1'b0, dd_q}) begin
      dr_nx    = DSW'(dsh - {1'b0, dd_q});
      dq_nx[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.div_mean_start || cmd_i.div_var_start) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= DCW'(DVW);
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (dcnt_q == DCW'(1)) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_mean_start) begin
      dq_q       <= DVW'(abs_q);
      dd_q       <= DSW'(fill_q);
      dr_q       <= '0;
      dsel_var_q <= 1'b0;
    end else if (cmd_i.div_var_start) begin
      dq_q       <= num_q;
      dd_q       <= nn_q;
      dr_q       <= '0;
      dsel_var_q <= 1'b1;
    end else if (dbusy_q) begin
      dq_q <= dq_nx;
      dr_q <= dr_nx;
      if (dcnt_q == DCW'(1)) begin
        if (dsel_var_q) var_q <= dq_nx[VW-1:0];
        else if (neg_q) mean_q <= -signed'(dq_nx[SB-1:0]);
        else mean_q <= signed'(dq_nx[SB-1:0]);
      end
    end
  end

  // square root, two radicand bits a cycle
  always_comb begin
    srn   = {sr_q[SB-1:0], sx_q[2*SB-1:2*SB-2]};
    trial = {root_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbusy_q <= 1'b0;
      rcnt_q  <= '0;
    end else if (cmd_i.sqrt_start) begin
      rbusy_q <= 1'b1;
      rcnt_q  <= RCW'(SB);
    end else if (rbusy_q) begin
      rcnt_q <= rcnt_q - 1'b1;
      if (rcnt_q == RCW'(1)) rbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sx_q   <= {1'b0, var_q};
      sr_q   <= '0;
      root_q <= '0;
    end else if (rbusy_q) begin
      sx_q <= {sx_q[2*SB-3:0], 2'b00};
      if (srn >= trial) begin
        sr_q   <= srn - trial;
        root_q <= {root_q[SB-2:0], 1'b1};
      end else begin
        sr_q   <= srn;
        root_q <= {root_q[SB-2:0], 1'b0};
      end
    end
  end

  // min / max walk over entries 0 .. count-1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      pend_q <= 1'b0;
      idx_q  <= '0;
    end else if (cmd_i.scan_start) begin
      run_q  <= 1'b1;
      pend_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      pend_q <= run_q && (idx_q < fill_q);
      if (run_q) begin
        if (idx_q < fill_q) idx_q <= idx_q + 1'b1;
        else run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) first_q <= 1'b1;
    else if (pend_q) begin
      first_q <= 1'b0;
      if (first_q || rd_s < lo_q) lo_q <= rd_s;
      if (first_q || rd_s > hi_q) hi_q <= rd_s;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      if (zero_q) begin
        valid_res_o       <= 1'b0;
        held_count_o      <= '0;
        mean_value_o      <= '0;
        variance_value_o  <= '0;
        deviation_value_o <= '0;
        smallest_o        <= '0;
        largest_o         <= '0;
      end else begin
        valid_res_o       <= 1'b1;
        held_count_o      <= fill_q;
        mean_value_o      <= mean_q;
        variance_value_o  <= var_q;
        deviation_value_o <= root_q;
        smallest_o        <= lo_q;
        largest_o         <= hi_q;
      end
    end
  end

endmodule
